// File: rtl/i2cm_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
package i2cm_pkg;

	localparam logic [7:0] TIMEOUT_RESET = 8'd250;
	localparam logic [3:0] BYTE_BITS     = 4'd8;
	localparam int         DATA_MSB      = 7;

	typedef enum logic [2:0] {
		CMD_IDLE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_WAIT  = 3'd5
	} cmd_t;

	typedef struct packed {
		logic scl;
		logic sda;
		logic en;
	} line_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [2:0] phase;
		logic [3:0] bit_count;
		logic [7:0] shift_data;
		logic [7:0] poll_count;
		logic       ack_choice;
		line_t      lines;
		logic       fail_flag;
		logic [7:0] rx_hold;
	} seq_state_t;

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       en;
		logic       busy;
		logic       done;
		logic [7:0] rx;
		logic       fail;
	} res_t;

endpackage

// File: rtl/i2cm_step.sv
// Next-state and result logic for one tick of the bit sequencer.
module i2cm_step import i2cm_pkg::*; (
	input  seq_state_t state_cur,
	input  logic [2:0] command,
	input  logic [7:0] tx_byte,
	input  logic       send_ack,
	input  logic       sda_sample,
	input  logic [7:0] ack_timeout,
	output seq_state_t state_nxt,
	output res_t       result
);

	typedef struct packed {
		line_t lines;
		logic  fin;
	} stop_t;

	// One step of the stop condition; the last step reports the end.
	function automatic stop_t stop_apply(input logic [2:0] step, input line_t l);
		stop_t r;
		r.lines = l;
		r.fin   = 1'b0;
		case (step)
			3'd0: begin
				r.lines.en  = 1'b1;
				r.lines.scl = 1'b0;
			end
			3'd1: r.lines.sda = 1'b0;
			3'd2: r.lines.scl = 1'b1;
			default: begin
				r.lines.sda = 1'b1;
				r.fin       = 1'b1;
			end
		endcase
		return r;
	endfunction

	seq_state_t n;
	stop_t      st;
	logic       fin;
	logic       is_cmd;

	assign is_cmd = (command == CMD_START) || (command == CMD_STOP) ||
	                (command == CMD_WRITE) || (command == CMD_READ) ||
	                (command == CMD_WAIT);

	always_comb begin
		n   = state_cur;
		fin = 1'b0;
		st  = stop_apply(state_cur.phase, state_cur.lines);

		// A new command is taken only while idle; otherwise it is dropped.
		if (state_cur.cmd == CMD_IDLE && is_cmd) begin
			n.cmd        = cmd_t'(command);
			n.phase      = 3'd0;
			n.bit_count  = 4'd0;
			n.poll_count = 8'd0;
			if (command == CMD_WRITE) begin
				n.shift_data = tx_byte;
			end
			if (command == CMD_READ) begin
				n.shift_data = 8'd0;
				n.ack_choice = send_ack;
			end
			if (command == CMD_WAIT) begin
				n.fail_flag = 1'b0;
			end
		end

		if (n.cmd != CMD_IDLE) begin
			case (n.cmd)
				CMD_START: begin
					case (n.phase)
						3'd0: begin
							n.lines.en  = 1'b1;
							n.lines.sda = 1'b1;
						end
						3'd1: n.lines.scl = 1'b1;
						3'd2: n.lines.sda = 1'b0;
						default: begin
							n.lines.scl = 1'b0;
							fin         = 1'b1;
						end
					endcase
					n.phase = n.phase + 3'd1;
				end
				CMD_STOP: begin
					st      = stop_apply(n.phase, n.lines);
					n.lines = st.lines;
					fin     = st.fin;
					n.phase = n.phase + 3'd1;
				end
				CMD_WRITE: begin
					if (n.phase == 3'd0) begin
						n.lines.en  = 1'b1;
						n.lines.scl = 1'b0;
						n.phase     = 3'd1;
					end else if (n.phase == 3'd1) begin
						n.lines.sda  = n.shift_data[DATA_MSB];
						n.shift_data = {n.shift_data[6:0], 1'b0};
						n.phase      = 3'd2;
					end else if (n.phase == 3'd2) begin
						n.lines.scl = 1'b1;
						n.phase     = 3'd3;
					end else begin
						n.lines.scl = 1'b0;
						n.bit_count = n.bit_count + 4'd1;
						if (n.bit_count >= BYTE_BITS) begin
							fin = 1'b1;
						end else begin
							n.phase = 3'd1;
						end
					end
				end
				CMD_READ: begin
					case (n.phase)
						3'd0: begin
							n.lines.en  = 1'b0;
							n.lines.scl = 1'b0;
							n.phase     = 3'd1;
						end
						3'd1: begin
							n.lines.scl  = 1'b1;
							n.shift_data = {n.shift_data[6:0], sda_sample};
							n.bit_count  = n.bit_count + 4'd1;
							n.phase      = (n.bit_count >= BYTE_BITS) ? 3'd2 : 3'd0;
						end
						3'd2: begin
							n.lines.scl = 1'b0;
							n.phase     = 3'd3;
						end
						3'd3: begin
							n.lines.en  = 1'b1;
							n.lines.sda = ~n.ack_choice;
							n.phase     = 3'd4;
						end
						3'd4: begin
							n.lines.scl = 1'b1;
							n.phase     = 3'd5;
						end
						default: begin
							n.lines.scl = 1'b0;
							n.rx_hold   = n.shift_data;
							fin         = 1'b1;
						end
					endcase
				end
				CMD_WAIT: begin
					if (n.phase == 3'd0) begin
						n.lines.en  = 1'b0;
						n.lines.sda = 1'b1;
						n.phase     = 3'd1;
					end else if (n.phase == 3'd1) begin
						n.lines.scl = 1'b1;
						n.phase     = 3'd2;
					end else if (n.phase == 3'd2) begin
						if (!sda_sample) begin
							n.lines.scl = 1'b0;
							fin         = 1'b1;
						end else if (n.poll_count < ack_timeout) begin
							n.poll_count = n.poll_count + 8'd1;
						end else begin
							// Timed out: the first stop step happens on this tick.
							st      = stop_apply(3'd0, n.lines);
							n.lines = st.lines;
							n.phase = 3'd3;
						end
					end else begin
						st      = stop_apply(n.phase - 3'd2, n.lines);
						n.lines = st.lines;
						if (st.fin) begin
							n.fail_flag = 1'b1;
							fin         = 1'b1;
						end else begin
							n.phase = n.phase + 3'd1;
						end
					end
				end
				default: fin = 1'b1;
			endcase
		end

		if (fin) begin
			n.cmd   = CMD_IDLE;
			n.phase = 3'd0;
		end

		state_nxt   = n;
		result.scl  = n.lines.scl;
		result.sda  = n.lines.sda;
		result.en   = n.lines.en;
		result.busy = (n.cmd != CMD_IDLE);
		result.done = fin;
		result.rx   = n.rx_hold;
		result.fail = n.fail_flag;
	end

endmodule

// File: rtl/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: input stage, state and result register.
//
// Each input transaction is one bus tick: a command (or tick only), the byte to
// send, the ACK choice for reads and the sampled SDA level. Every tick produces
// exactly one result transaction with the driven SCL/SDA levels, the SDA drive
// enable, busy and done flags, the last received byte and the ACK failure flag.
// Commands that arrive while a sequence is running are discarded.
//
// A transaction is held in an input register and the state update on it is
// combinational; when it advances, the result is written to the output register.
// Throughput is one transaction per cycle while the receiver does not stall, set
// by the single state update between the input and output registers.
// When the receiver stalls, the output register holds its result and one more
// input transaction is still taken into the input register; only then is
// in_stall raised, combinationally from out_stall.
//
// Reset leaves the sequencer idle with SCL and SDA high and SDA driven, the
// timeout register at 250 and both channels empty. ack_timeout is written with
// ack_timeout_we and should only change while the sequencer is idle.
module i2c_master_bit_sequencer import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ack_timeout_we,
	input  logic [7:0] ack_timeout_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] command,
	input  logic [7:0] tx_byte,
	input  logic       send_ack,
	input  logic       sda_sample,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic       sda_drive_enable,
	output logic       busy_res,
	output logic       command_done,
	output logic [7:0] rx_byte,
	output logic       ack_failed
);

	logic       valid_s1;
	logic [2:0] command_s1;
	logic [7:0] tx_byte_s1;
	logic       send_ack_s1;
	logic       sda_sample_s1;

	logic [7:0] ack_timeout_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	res_t       result;
	res_t       res_q;
	logic       out_valid_q;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_timeout_q <= TIMEOUT_RESET;
		end else if (ack_timeout_we) begin
			ack_timeout_q <= ack_timeout_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			command_s1    <= command;
			tx_byte_s1    <= tx_byte;
			send_ack_s1   <= send_ack;
			sda_sample_s1 <= sda_sample;
		end
	end

	i2cm_step u_step (
		.state_cur   (state_q),
		.command     (command_s1),
		.tx_byte     (tx_byte_s1),
		.send_ack    (send_ack_s1),
		.sda_sample  (sda_sample_s1),
		.ack_timeout (ack_timeout_q),
		.state_nxt   (state_nxt),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.cmd        <= CMD_IDLE;
			state_q.phase      <= 3'd0;
			state_q.bit_count  <= 4'd0;
			state_q.shift_data <= 8'd0;
			state_q.poll_count <= 8'd0;
			state_q.ack_choice <= 1'b0;
			state_q.lines      <= '{scl: 1'b1, sda: 1'b1, en: 1'b1};
			state_q.fail_flag  <= 1'b0;
			state_q.rx_hold    <= 8'd0;
			out_valid_q        <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= result;
		end
	end

	assign out_valid        = out_valid_q;
	assign scl_level        = res_q.scl;
	assign sda_level        = res_q.sda;
	assign sda_drive_enable = res_q.en;
	assign busy_res         = res_q.busy;
	assign command_done     = res_q.done;
	assign rx_byte          = res_q.rx;
	assign ack_failed       = res_q.fail;

endmodule

// File: rtl/i2cm_checker.sv
// Port-level assertions for the I2C master bit sequencer, bound to the top level.
module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_level,
	input logic       sda_level,
	input logic       sda_drive_enable,
	input logic       busy_res,
	input logic       command_done,
	input logic [7:0] rx_byte,
	input logic       ack_failed
);

	// A finished sequence is never reported as still busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_done |-> !busy_res)
		else $error("command_done with busy_res set");

	// Only a stop condition ends with SCL high, and it leaves SDA driven high.
	a_done_scl_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && command_done && scl_level |-> sda_level && sda_drive_enable)
		else $error("sequence ended with SCL high but SDA not driven high");

	// The input side can only be held off once a result is waiting.
	a_stall_needs_output: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("in_stall raised with an empty output register");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable({scl_level, sda_level, sda_drive_enable,
			busy_res, command_done, rx_byte, ack_failed}))
		else $error("output payload changed while stalled");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (.*);
